### hdl/pmsc_pkg.sv
// shared types, constants and arithmetic helpers for the polar motion site correction
// used by pmsc_cordic and polar_motion_site_correction_top
package pmsc_pkg;

  typedef logic signed [63:0] q_t;

  localparam int QB = 60;
  localparam int OUT_W = 48;
  localparam int ANGLE_FRAC_BITS_DEF = 45;
  localparam int CORDIC_STAGES_DEF = 48;

  localparam q_t ONE_Q = 64'sh1000_0000_0000_0000;
  localparam q_t PI_Q = 64'sh3243_F6A8_885A_308D;
  localparam q_t HALF_PI_Q = PI_Q / 2;
  localparam q_t QUARTER_PI_Q = 64'sh0C90_FDAA_2216_8C23;
  localparam logic [63:0] TWO_PI_Q = 64'h6487_ED51_10B4_611A;
  localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        neg;
    logic [63:0] lo;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] hi;
  } mul_part_t;

  typedef struct packed {
    q_t xnm;
    q_t ynm;
    q_t znm;
  } pole_t;

  function automatic q_t atan_q(int i);
    logic [63:0] s;
    logic [63:0] term;
    int e;
    s = '0;
    if (i == 0) begin
      return QUARTER_PI_Q;
    end
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if ((k % 2) == 0) begin
          s = s + term;
        end else begin
          s = s - term;
        end
      end
    end
    return q_t'((s + 64'd2) >> 2);
  endfunction

  function automatic q_t gain_inv_q(int n);
    q_t x;
    q_t y;
    q_t dx;
    q_t dy;
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] q;
    x = ONE_Q;
    y = '0;
    q = '0;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    d = 64'(x);
    rem = 64'd1 << QB;
    if (d > rem) begin
      for (int i = 0; i < QB; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 64'd1;
        end
      end
    end
    return q_t'(q);
  endfunction

  function automatic mul_part_t mul_part(q_t a, q_t b);
    mul_part_t p;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] b0;
    logic [31:0] b1;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    a0 = ua[31:0];
    a1 = ua[63:32];
    b0 = ub[31:0];
    b1 = ub[63:32];
    p.neg = (a < 0) != (b < 0);
    p.lo = {32'd0, a0} * {32'd0, b0};
    p.m1 = {32'd0, a1} * {32'd0, b0};
    p.m2 = {32'd0, a0} * {32'd0, b1};
    p.hi = {32'd0, a1} * {32'd0, b1};
    return p;
  endfunction

  function automatic q_t mul_fin(mul_part_t p);
    logic [127:0] s;
    logic [63:0] r;
    s = {64'd0, p.lo} + {32'd0, p.m1, 32'd0} + {32'd0, p.m2, 32'd0} + {p.hi, 64'd0}
      + (128'd1 << (QB - 1));
    r = s[QB + 63:QB];
    if (s[127:QB + 63] != '0 || r[63]) begin
      r = 64'(Q_MAX);
    end
    return p.neg ? -q_t'(r) : q_t'(r);
  endfunction

  function automatic logic [OUT_W-1:0] emit(q_t q, int sh);
    q_t v;
    q_t top;
    top = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    v = q;
    if (sh > 0) begin
      v = (q + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    if (v > top) begin
      v = top;
    end
    if (v < -top - 64'sd1) begin
      v = -top - 64'sd1;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

### hdl/pmsc_cordic.sv
// pipelined cordic, one register stage per iteration, rotation or vectoring mode
// depends on pmsc_pkg for the angle table, gain constant and number format
module pmsc_cordic #(
  parameter bit VECTOR = 1'b0,
  parameter int STAGES = pmsc_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  pmsc_pkg::q_t      a_in,
  input  pmsc_pkg::q_t      b_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output pmsc_pkg::q_t      res_a,
  output pmsc_pkg::q_t      res_b,
  output logic              zero,
  output logic [SIDE_W-1:0] side_out
);
  import pmsc_pkg::*;

  localparam q_t GAIN_INV = gain_inv_q(STAGES);

  typedef struct packed {
    q_t                x;
    q_t                y;
    q_t                z;
    q_t                off;
    logic              neg;
    logic              zero;
    logic [SIDE_W-1:0] side;
  } stg_t;

  stg_t pre;
  stg_t stg [STAGES+1];
  logic [STAGES:0] vld;

  function automatic stg_t iter(stg_t s, int sh, q_t at);
    stg_t n;
    q_t dx;
    q_t dy;
    logic d;
    n = s;
    dx = s.y >>> sh;
    dy = s.x >>> sh;
    d = VECTOR ? (s.y >= 0) : (s.z >= 0);
    if (d != VECTOR) begin
      n.x = s.x - dx;
      n.y = s.y + dy;
      n.z = s.z - at;
    end else begin
      n.x = s.x + dx;
      n.y = s.y - dy;
      n.z = s.z + at;
    end
    return n;
  endfunction

  always_comb begin
    pre.side = side_in;
    pre.neg = 1'b0;
    pre.zero = 1'b0;
    pre.off = '0;
    pre.x = '0;
    pre.y = '0;
    pre.z = '0;
    if (VECTOR) begin
      pre.x = b_in;
      pre.y = a_in;
      pre.zero = (a_in == '0) && (b_in == '0);
      if (b_in < 0) begin
        pre.off = (a_in >= 0) ? PI_Q : -PI_Q;
        pre.x = -b_in;
        pre.y = -a_in;
      end
    end else begin
      pre.x = GAIN_INV;
      pre.z = a_in;
      if (a_in > HALF_PI_Q) begin
        pre.z = a_in - PI_Q;
        pre.neg = 1'b1;
      end else if (a_in < -HALF_PI_Q) begin
        pre.z = a_in + PI_Q;
        pre.neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[STAGES-1:0], in_valid};
      out_valid <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= pre;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam q_t AT = atan_q(i);
    always_ff @(posedge clk) begin
      if (en) begin
        stg[i+1] <= iter(stg[i], i, AT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= stg[STAGES].side;
      zero <= stg[STAGES].zero;
      if (VECTOR) begin
        res_a <= stg[STAGES].zero ? '0 : stg[STAGES].z + stg[STAGES].off;
        res_b <= stg[STAGES].x;
      end else begin
        res_a <= stg[STAGES].neg ? -stg[STAGES].y : stg[STAGES].y;
        res_b <= stg[STAGES].neg ? -stg[STAGES].x : stg[STAGES].x;
      end
    end
  end

endmodule

### hdl/polar_motion_site_correction_top.sv
// polar motion correction of a site position, top level pipeline
// depends on pmsc_pkg and pmsc_cordic
//
// The block takes one transaction per clock while site_stall is low and returns one result per
// transaction, in order. The pipeline is an angle reduction of registered subtract steps
// followed by four cordic chains in series (sin/cos of the inputs, the site atan2, the latitude
// atan2 in parallel with sin/cos of the true longitude, and the azimuth atan2), each one
// register per iteration, plus split 64-bit multipliers that register the partial products
// and then the finished product. While a result waits on corr_stall the whole pipeline
// holds and site_stall is raised.
module polar_motion_site_correction_top #(
  parameter int ANGLE_FRAC_BITS = pmsc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = pmsc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               site_valid,
  output logic               site_stall,
  input  logic signed [47:0] mean_longitude,
  input  logic signed [47:0] mean_latitude,
  input  logic signed [35:0] pole_x,
  input  logic signed [35:0] pole_y,
  output logic               corr_valid,
  input  logic               corr_stall,
  output logic signed [47:0] true_longitude,
  output logic signed [47:0] true_latitude,
  output logic signed [47:0] azimuth_correction
);
  import pmsc_pkg::*;

  localparam int SH = QB - ANGLE_FRAC_BITS;
  localparam logic [63:0] HALF = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
  localparam logic [63:0] TP = (TWO_PI_Q + HALF) >> SH;
  localparam q_t HALF_TP = q_t'(TP / 2);
  localparam int RSTEPS = (45 - ANGLE_FRAC_BITS > 1) ? 45 - ANGLE_FRAC_BITS : 1;
  localparam q_t GAIN_INV = gain_inv_q(CORDIC_STAGES);

  typedef struct packed {
    q_t    zt;
    pole_t pole;
  } s1_t;

  typedef struct packed {
    q_t    tl;
    q_t    zt;
    q_t    r;
    pole_t pole;
  } s2_t;

  typedef struct packed {
    q_t tl;
    q_t tp;
  } s3_t;

  logic adv;
  q_t   in_ext [4];

  assign adv = !corr_valid || !corr_stall;
  assign site_stall = !adv;

  always_comb begin
    in_ext[0] = q_t'(mean_longitude);
    in_ext[1] = q_t'(mean_latitude);
    in_ext[2] = q_t'(pole_x);
    in_ext[3] = q_t'(pole_y);
  end

  // angle reduction
  logic [63:0]   rrem [RSTEPS+1][4];
  logic [3:0]    rneg [RSTEPS+1];
  logic [RSTEPS:0] rvld;
  q_t            fz [4];
  logic          fz_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld <= '0;
      fz_v <= 1'b0;
    end else if (adv) begin
      rvld <= {rvld[RSTEPS-1:0], site_valid};
      fz_v <= rvld[RSTEPS];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        rneg[0][l] <= in_ext[l] < 0;
        rrem[0][l] <= (in_ext[l] < 0) ? 64'(-in_ext[l]) : 64'(in_ext[l]);
      end
    end
    for (genvar k = 0; k < RSTEPS; k++) begin : g_step
      localparam logic [63:0] DIV = TP << (RSTEPS - 1 - k);
      always_ff @(posedge clk) begin
        if (adv) begin
          rneg[k+1][l] <= rneg[k][l];
          rrem[k+1][l] <= (rrem[k][l] >= DIV) ? rrem[k][l] - DIV : rrem[k][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      q_t r;
      r = rneg[RSTEPS][l] ? -q_t'(rrem[RSTEPS][l]) : q_t'(rrem[RSTEPS][l]);
      if (r > HALF_TP) begin
        r = r - q_t'(TP);
      end else if (r < -HALF_TP) begin
        r = r + q_t'(TP);
      end
      if (adv) begin
        fz[l] <= r <<< SH;
      end
    end
  end

  // sin and cos of the four input angles
  q_t   rs [4];
  q_t   rc [4];
  logic rv [4];

  for (genvar l = 0; l < 4; l++) begin : g_rot
    pmsc_cordic #(
      .VECTOR(1'b0),
      .STAGES(CORDIC_STAGES),
      .SIDE_W(1)
    ) u_rot (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (fz_v),
      .a_in     (fz[l]),
      .b_in     ('0),
      .side_in  (1'b0),
      .out_valid(rv[l]),
      .res_a    (rs[l]),
      .res_b    (rc[l]),
      .zero     (),
      .side_out ()
    );
  end

  // site vector and first rotation
  mul_part_t m1p_xm, m1p_ym, m1p_xn, m1p_zn;
  q_t        m1p_zm, m1p_sx, m1p_cx, m1p_sy, m1p_cy;
  logic      m1p_v;
  q_t        m1f_xm, m1f_ym, m1f_xn, m1f_zn, m1f_zm, m1f_sx, m1f_cx, m1f_sy, m1f_cy;
  logic      m1f_v;
  mul_part_t m2p_a, m2p_b, m2p_c, m2p_d;
  q_t        m2p_xm, m2p_sx, m2p_cx;
  pole_t     m2p_pole;
  logic      m2p_v;
  q_t        m2f_a, m2f_b, m2f_c, m2f_d, m2f_xm, m2f_sx, m2f_cx;
  pole_t     m2f_pole;
  logic      m2f_v;
  q_t        m2s_zw, m2s_yt, m2s_xm, m2s_sx, m2s_cx;
  pole_t     m2s_pole;
  logic      m2s_v;
  mul_part_t m3p_a, m3p_b, m3p_c, m3p_d;
  q_t        m3p_yt;
  pole_t     m3p_pole;
  logic      m3p_v;
  q_t        m3f_a, m3f_b, m3f_c, m3f_d, m3f_yt;
  pole_t     m3f_pole;
  logic      m3f_v;
  q_t        m3s_xt, m3s_yt;
  s1_t       m3s_side;
  logic      m3s_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1p_v <= 1'b0;
      m1f_v <= 1'b0;
      m2p_v <= 1'b0;
      m2f_v <= 1'b0;
      m2s_v <= 1'b0;
      m3p_v <= 1'b0;
      m3f_v <= 1'b0;
      m3s_v <= 1'b0;
    end else if (adv) begin
      m1p_v <= rv[0];
      m1f_v <= m1p_v;
      m2p_v <= m1f_v;
      m2f_v <= m2p_v;
      m2s_v <= m2f_v;
      m3p_v <= m2s_v;
      m3f_v <= m3p_v;
      m3s_v <= m3f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1p_xm <= mul_part(rc[0], rc[1]);
      m1p_ym <= mul_part(rs[0], rc[1]);
      m1p_xn <= mul_part(rs[2], rc[3]);
      m1p_zn <= mul_part(rc[2], rc[3]);
      m1p_zm <= rs[1];
      m1p_sx <= rs[2];
      m1p_cx <= rc[2];
      m1p_sy <= rs[3];
      m1p_cy <= rc[3];

      m1f_xm <= mul_fin(m1p_xm);
      m1f_ym <= mul_fin(m1p_ym);
      m1f_xn <= mul_fin(m1p_xn);
      m1f_zn <= mul_fin(m1p_zn);
      m1f_zm <= m1p_zm;
      m1f_sx <= m1p_sx;
      m1f_cx <= m1p_cx;
      m1f_sy <= m1p_sy;
      m1f_cy <= m1p_cy;

      m2p_a <= mul_part(m1f_zm, m1f_cy);
      m2p_b <= mul_part(m1f_ym, m1f_sy);
      m2p_c <= mul_part(m1f_ym, m1f_cy);
      m2p_d <= mul_part(m1f_zm, m1f_sy);
      m2p_xm <= m1f_xm;
      m2p_sx <= m1f_sx;
      m2p_cx <= m1f_cx;
      m2p_pole.xnm <= -m1f_xn;
      m2p_pole.ynm <= m1f_sy;
      m2p_pole.znm <= m1f_zn;

      m2f_a <= mul_fin(m2p_a);
      m2f_b <= mul_fin(m2p_b);
      m2f_c <= mul_fin(m2p_c);
      m2f_d <= mul_fin(m2p_d);
      m2f_xm <= m2p_xm;
      m2f_sx <= m2p_sx;
      m2f_cx <= m2p_cx;
      m2f_pole <= m2p_pole;

      m2s_zw <= m2f_a - m2f_b;
      m2s_yt <= m2f_c + m2f_d;
      m2s_xm <= m2f_xm;
      m2s_sx <= m2f_sx;
      m2s_cx <= m2f_cx;
      m2s_pole <= m2f_pole;

      m3p_a <= mul_part(m2s_xm, m2s_cx);
      m3p_b <= mul_part(m2s_zw, m2s_sx);
      m3p_c <= mul_part(m2s_xm, m2s_sx);
      m3p_d <= mul_part(m2s_zw, m2s_cx);
      m3p_yt <= m2s_yt;
      m3p_pole <= m2s_pole;

      m3f_a <= mul_fin(m3p_a);
      m3f_b <= mul_fin(m3p_b);
      m3f_c <= mul_fin(m3p_c);
      m3f_d <= mul_fin(m3p_d);
      m3f_yt <= m3p_yt;
      m3f_pole <= m3p_pole;

      m3s_xt <= m3f_a - m3f_b;
      m3s_yt <= m3f_yt;
      m3s_side.zt <= m3f_c + m3f_d;
      m3s_side.pole <= m3f_pole;
    end
  end

  // true longitude and horizontal magnitude
  logic v1_v, v1_zero;
  q_t   v1_tl, v1_x;
  s1_t  v1_side;

  pmsc_cordic #(
    .VECTOR(1'b1),
    .STAGES(CORDIC_STAGES),
    .SIDE_W($bits(s1_t))
  ) u_vec_lon (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (m3s_v),
    .a_in     (m3s_yt),
    .b_in     (m3s_xt),
    .side_in  (m3s_side),
    .out_valid(v1_v),
    .res_a    (v1_tl),
    .res_b    (v1_x),
    .zero     (v1_zero),
    .side_out (v1_side)
  );

  mul_part_t mgp_m;
  q_t        mgp_tl, mgf_tl, mgf_r;
  logic      mgp_v, mgf_v;
  s1_t       mgp_side, mgf_side;
  s2_t       mgf_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mgp_v <= 1'b0;
      mgf_v <= 1'b0;
    end else if (adv) begin
      mgp_v <= v1_v;
      mgf_v <= mgp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mgp_m <= mul_part(v1_x, GAIN_INV);
      mgp_tl <= v1_tl;
      mgp_side <= v1_side;
      mgf_r <= mul_fin(mgp_m);
      mgf_tl <= mgp_tl;
      mgf_side <= mgp_side;
    end
  end

  always_comb begin
    mgf_s2.tl = mgf_tl;
    mgf_s2.zt = mgf_side.zt;
    mgf_s2.r = mgf_r;
    mgf_s2.pole = mgf_side.pole;
  end

  // true latitude in parallel with sin and cos of the true longitude
  logic t_v, v2_v;
  q_t   t_s, t_c, v2_tp;
  s2_t  v2_side;

  pmsc_cordic #(
    .VECTOR(1'b0),
    .STAGES(CORDIC_STAGES),
    .SIDE_W(1)
  ) u_rot_lon (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (mgf_v),
    .a_in     (mgf_tl),
    .b_in     ('0),
    .side_in  (1'b0),
    .out_valid(t_v),
    .res_a    (t_s),
    .res_b    (t_c),
    .zero     (),
    .side_out ()
  );

  pmsc_cordic #(
    .VECTOR(1'b1),
    .STAGES(CORDIC_STAGES),
    .SIDE_W($bits(s2_t))
  ) u_vec_lat (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (mgf_v),
    .a_in     (mgf_side.zt),
    .b_in     (mgf_r),
    .side_in  (mgf_s2),
    .out_valid(v2_v),
    .res_a    (v2_tp),
    .res_b    (),
    .zero     (),
    .side_out (v2_side)
  );

  // pole direction in the site frame
  q_t        stl, ctl;
  mul_part_t h1p_a, h1p_b, h1p_c, h1p_d, h1p_e;
  q_t        h1p_zt, h1p_tl, h1p_tp;
  logic      h1p_v;
  q_t        h1f_a, h1f_b, h1f_c, h1f_d, h1f_e, h1f_zt, h1f_tl, h1f_tp;
  logic      h1f_v;
  q_t        h1s_u, h1s_ynt, h1s_e, h1s_zt, h1s_tl, h1s_tp;
  logic      h1s_v;
  mul_part_t h2p_m;
  q_t        h2p_ynt, h2p_e, h2p_tl, h2p_tp;
  logic      h2p_v;
  q_t        h2f_m, h2f_ynt, h2f_e, h2f_tl, h2f_tp;
  logic      h2f_v;
  q_t        h2s_nx, h2s_ny;
  s3_t       h2s_side;
  logic      h2s_v;

  always_comb begin
    stl = t_s;
    ctl = t_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1p_v <= 1'b0;
      h1f_v <= 1'b0;
      h1s_v <= 1'b0;
      h2p_v <= 1'b0;
      h2f_v <= 1'b0;
      h2s_v <= 1'b0;
    end else if (adv) begin
      h1p_v <= t_v;
      h1f_v <= h1p_v;
      h1s_v <= h1f_v;
      h2p_v <= h1s_v;
      h2f_v <= h2p_v;
      h2s_v <= h2f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1p_a <= mul_part(v2_side.pole.xnm, ctl);
      h1p_b <= mul_part(v2_side.pole.ynm, stl);
      h1p_c <= mul_part(v2_side.pole.ynm, ctl);
      h1p_d <= mul_part(v2_side.pole.xnm, stl);
      h1p_e <= mul_part(v2_side.pole.znm, v2_side.r);
      h1p_zt <= v2_side.zt;
      h1p_tl <= v2_side.tl;
      h1p_tp <= v2_tp;

      h1f_a <= mul_fin(h1p_a);
      h1f_b <= mul_fin(h1p_b);
      h1f_c <= mul_fin(h1p_c);
      h1f_d <= mul_fin(h1p_d);
      h1f_e <= mul_fin(h1p_e);
      h1f_zt <= h1p_zt;
      h1f_tl <= h1p_tl;
      h1f_tp <= h1p_tp;

      h1s_u <= h1f_a + h1f_b;
      h1s_ynt <= h1f_c - h1f_d;
      h1s_e <= h1f_e;
      h1s_zt <= h1f_zt;
      h1s_tl <= h1f_tl;
      h1s_tp <= h1f_tp;

      h2p_m <= mul_part(h1s_u, h1s_zt);
      h2p_ynt <= h1s_ynt;
      h2p_e <= h1s_e;
      h2p_tl <= h1s_tl;
      h2p_tp <= h1s_tp;

      h2f_m <= mul_fin(h2p_m);
      h2f_ynt <= h2p_ynt;
      h2f_e <= h2p_e;
      h2f_tl <= h2p_tl;
      h2f_tp <= h2p_tp;

      h2s_nx <= -(h2f_m - h2f_e);
      h2s_ny <= -h2f_ynt;
      h2s_side.tl <= h2f_tl;
      h2s_side.tp <= h2f_tp;
    end
  end

  // azimuth of the pole
  logic v3_v;
  q_t   v3_az;
  s3_t  v3_side;

  pmsc_cordic #(
    .VECTOR(1'b1),
    .STAGES(CORDIC_STAGES),
    .SIDE_W($bits(s3_t))
  ) u_vec_az (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (h2s_v),
    .a_in     (h2s_ny),
    .b_in     (h2s_nx),
    .side_in  (h2s_side),
    .out_valid(v3_v),
    .res_a    (v3_az),
    .res_b    (),
    .zero     (),
    .side_out (v3_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_valid <= 1'b0;
    end else if (adv) begin
      corr_valid <= v3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      true_longitude <= emit(v3_side.tl, SH);
      true_latitude <= emit(v3_side.tp, SH);
      azimuth_correction <= emit(v3_az, SH);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(rvld) && $stable(m3s_v) && $stable(h2s_v))
    else $error("pipeline valid moved while held");

  a_reset: assert property (@(posedge clk) rst |=> !corr_valid && rvld == '0)
    else $error("valid not cleared by reset");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    v1_v && v1_zero |-> v1_tl == '0)
    else $error("longitude not zero on axis");

  a_align: assert property (@(posedge clk) disable iff (rst) t_v == v2_v)
    else $error("parallel cordic chains out of step");

endmodule
